// File: src/qea_pkg.sv
// Package for the quadrature encoder with step acceleration.
// Item and result types, command codes, constants and the quadrature table.
// No dependencies.
`default_nettype none

package qea_pkg;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam int          TIME_W        = 32;
    localparam int          STEP_W        = 5;
    localparam logic [31:0] THRESH_RESET  = 32'd30000;
    localparam logic signed [3:0] QUARTER_FULL = 4'sd4;
    localparam logic signed [4:0] STEP_SLOW    = 5'sd1;
    localparam logic signed [4:0] STEP_FAST    = 5'sd10;

    typedef struct packed {
        logic              command;
        logic              pin_a;
        logic              pin_b;
        logic [TIME_W-1:0] time_us;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    typedef struct packed {
        logic                     valid;
        logic signed [STEP_W-1:0] step_value;
    } t_result;

    // index is {previous phase, current phase}, phase = {B, A}
    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        begin
            case (idx)
                4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
                4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
                default: d = 2'sd0;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/qea_item_if.sv
// Valid/ready channels of the encoder block: input items and read results.
// No dependencies.
`default_nettype none

interface qea_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] time_us;

    modport source(output valid, command, pin_a, pin_b, time_us, input ready);
    modport sink(input valid, command, pin_a, pin_b, time_us, output ready);
endinterface

interface qea_result_if;
    logic              valid;
    logic              ready;
    logic signed [4:0] step_value;

    modport source(output valid, step_value, input ready);
    modport sink(input valid, step_value, output ready);
endinterface

`default_nettype wire

// File: src/qea_in_stage.sv
// Input register of the encoder block: holds one beat until the core takes it.
// Depends on qea_pkg.
`default_nettype none

module qea_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire qea_pkg::t_item i_item,
    input  wire logic           i_take,
    output qea_pkg::t_stage     o_stage
);
    import qea_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

`default_nettype wire

// File: src/qea_core.sv
// Decode, quarter-step accumulation, acceleration compare and pending value.
// Depends on qea_pkg.
`default_nettype none

module qea_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [31:0]     i_cfg_wdata,
    input  wire qea_pkg::t_stage i_stage,
    input  wire logic            i_out_free,
    output logic                 o_take,
    output qea_pkg::t_result     o_result
);
    import qea_pkg::*;

    logic [TIME_W-1:0]        r_thresh;
    logic [1:0]               r_phase;
    logic                     r_phase_known;
    logic signed [3:0]        r_accum;
    logic [TIME_W-1:0]        r_last_time;
    logic signed [STEP_W-1:0] r_pending;

    logic [1:0]               now_phase;
    logic signed [1:0]        delta;
    logic signed [3:0]        sum;
    logic                     full_step;
    logic [TIME_W-1:0]        dt;
    logic signed [STEP_W-1:0] mag;
    logic                     is_read;
    logic                     do_sample;

    assign is_read   = (i_stage.item.command == CMD_READ);
    assign o_take    = i_stage.valid && (!is_read || i_out_free);
    assign do_sample = o_take && !is_read;

    assign now_phase = {i_stage.item.pin_b, i_stage.item.pin_a};
    assign delta     = quad_delta({r_phase, now_phase});
    assign sum       = r_accum + {{2{delta[1]}}, delta};
    assign full_step = (sum == QUARTER_FULL) || (sum == -QUARTER_FULL);
    assign dt        = i_stage.item.time_us - r_last_time;
    assign mag       = (dt < r_thresh) ? STEP_FAST : STEP_SLOW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh      <= THRESH_RESET;
            r_phase       <= 2'd0;
            r_phase_known <= 1'b0;
            r_accum       <= 4'sd0;
            r_last_time   <= '0;
            r_pending     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (o_take && is_read) begin
                r_pending <= '0;
            end
            if (do_sample) begin
                r_phase       <= now_phase;
                r_phase_known <= 1'b1;
                if (r_phase_known) begin
                    if (full_step) begin
                        r_accum     <= 4'sd0;
                        r_last_time <= i_stage.item.time_us;
                        r_pending   <= sum[3] ? -mag : mag;
                    end else begin
                        r_accum <= sum;
                    end
                end
            end
        end
    end

    assign o_result.valid      = o_take && is_read;
    assign o_result.step_value = r_pending;

`ifndef SYNTHESIS
    a_accum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accum <= 4'sd3) && (r_accum >= -4'sd3))
        else $error("quarter accumulator out of range");

    a_pending_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 5'sd0) || (r_pending == STEP_SLOW) || (r_pending == -STEP_SLOW)
        || (r_pending == STEP_FAST) || (r_pending == -STEP_FAST))
        else $error("pending step value not a legal code");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |=> (r_pending == 5'sd0))
        else $error("read did not clear pending value");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> i_out_free)
        else $error("result issued into an occupied output register");
`endif

endmodule

`default_nettype wire

// File: src/qea_out_reg.sv
// Result register of the encoder block: holds one read beat for the consumer.
// Depends on qea_pkg.
`default_nettype none

module qea_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qea_pkg::t_result  i_result,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [4:0]      o_step_value
);
    import qea_pkg::*;

    logic                     r_valid;
    logic signed [STEP_W-1:0] r_step;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_step <= i_result.step_value;
        end
    end

    assign o_valid      = r_valid;
    assign o_step_value = r_step;

endmodule

`default_nettype wire

// File: src/quadrature_encoder_accel_stepper.sv
// Top level of the x4 quadrature encoder with step acceleration.
// Depends on qea_pkg, qea_item_if, qea_result_if, qea_in_stage, qea_core, qea_out_reg.
//
//  channel   dir  beat contents                          when
//  i_item    in   command, pin_a, pin_b, time_us         valid && ready
//  o_result  out  step_value (signed 5 bit)              valid && ready, one per read
//  cfg       in   i_cfg_wdata = accel_threshold_us       i_cfg_we
//
// One beat per cycle while the input stage is not held; a beat is registered in the input
// register, and a read result is registered in the output register when the core takes it.
// Only a read waiting on a full, stalled output register holds the input stage.
// Synchronous active-low reset; threshold resets to 30000 us.
`default_nettype none

module quadrature_encoder_accel_stepper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    qea_item_if.sink         i_item,
    qea_result_if.source     o_result
);
    import qea_pkg::*;

    t_item   in_item;
    t_stage  stage;
    t_result result;
    logic    take;
    logic    out_free;

    assign in_item.command = i_item.command;
    assign in_item.pin_a   = i_item.pin_a;
    assign in_item.pin_b   = i_item.pin_b;
    assign in_item.time_us = i_item.time_us;

    qea_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_stage (stage)
    );

    qea_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (stage),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_result    (result)
    );

    qea_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (result),
        .o_free       (out_free),
        .o_valid      (o_result.valid),
        .i_ready      (o_result.ready),
        .o_step_value (o_result.step_value)
    );

endmodule

`default_nettype wire
